### design/ftwa_pkg.sv
package ftwa_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_TRAFFIC = 2'd0,
        CMD_BLOCK   = 2'd1,
        CMD_CLEAN   = 2'd2,
        CMD_MERGE   = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NO_SRC = 2'd2;

    localparam logic [7:0] REG_MAX_IDLE  = 8'd0;
    localparam logic [7:0] REG_MIN_FLOWS = 8'd1;

    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic                blocked;
        logic [31:0]         packets;
        logic [31:0]         bytes;
        logic [31:0]         last_seen;
        logic [7:0]          idle;
        logic                active;
        logic                mark;
    } entry_t;

    typedef struct packed {
        logic                mark;
        logic [KEY_BITS-1:0] key;
    } probe_t;

    typedef struct packed {
        logic             shift;
        logic             probe_load;
        logic             probe_shift;
        logic             prune;
        logic [CNT_W-1:0] budget;
    } cell_ctrl_t;

endpackage

### design/ftwa_cell.sv
module ftwa_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ftwa_pkg::cell_ctrl_t ctrl,
    input  ftwa_pkg::entry_t    entry_in,
    output ftwa_pkg::entry_t    entry_out,
    input  ftwa_pkg::probe_t    probe_in,
    output ftwa_pkg::probe_t    probe_out
);
    import ftwa_pkg::*;

    logic             valid_reg;
    entry_t           data_reg;
    probe_t           probe_reg;
    logic [CNT_W-1:0] rank_reg;

    // The valid bit travels with the entry but is the only part under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= entry_in.valid;
        end
        else if (ctrl.prune && data_reg.mark && (rank_reg < ctrl.budget))
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= entry_in;
        end
        else if (ctrl.prune)
        begin
            data_reg.mark <= 1'b0;
        end

        // Rank counts the marked entries whose key is below this one.
        if (ctrl.probe_load)
        begin
            probe_reg <= '{mark: data_reg.mark, key: data_reg.key};
            rank_reg  <= '0;
        end
        else if (ctrl.probe_shift)
        begin
            probe_reg <= probe_in;
            if (probe_reg.mark && (probe_reg.key < data_reg.key))
            begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        entry_out       = data_reg;
        entry_out.valid = valid_reg;
    end

    assign probe_out = probe_reg;

endmodule

### design/flow_table_with_aging.sv
// Only one item is in flight: a new item is taken only in the idle state, after the result
// of the last one is registered. Traffic, set block and merge run two passes of the ring
// and the finish step; a clean tick runs a pass, probe load, probe turn, prune and finish.
// A lookup takes two full turns of the ring, a clean tick one turn plus a turn of the key
// probes, and a result still waiting at the output holds back the next one.
// Reset: all entries invalid, flow count zero, idle limit 10, min_flows 5; usable at once.
module flow_table_with_aging (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [15:0] peer_id,
    input  logic [15:0] new_peer_id,
    input  logic [15:0] packet_count,
    input  logic [23:0] byte_count,
    input  logic [31:0] time_stamp,
    input  logic        block_flag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [6:0]  flow_count,
    output logic [6:0]  removed_count,
    output logic [31:0] packet_total,
    output logic [31:0] byte_total
);
    import ftwa_pkg::*;

    // The table is a ring of cells. During a pass the entries rotate one cell per cycle,
    // and the controller sees and may rewrite the entry leaving cell 0 before it enters
    // the last cell. A slot's position is never visible outside, so any free slot
    // may take a new entry.
    //
    // Clean tick: the first pass ages every entry and marks the removal candidates.
    // Then each cell loads a probe with its key and mark, and the probes rotate one full
    // turn while the entries stand still, so each cell learns how many candidates have
    // a smaller key. Walking in key order removes the smallest candidates until the count
    // falls to min_flows, so a candidate goes exactly when its rank is below the budget
    // of count minus min_flows. The prune step applies this in all cells at once.

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS1,
        S_PASS2,
        S_PLOAD,
        S_PROBE,
        S_PRUNE,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [IDX_W-1:0]     cnt_reg;
    logic [7:0]           max_idle_reg;
    logic [6:0]           min_flows_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     ncand_reg;
    logic [CNT_W-1:0]     removed_reg;

    cmd_t                 cmd_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [KEY_BITS-1:0]  key2_reg;
    logic [15:0]          pk_reg;
    logic [23:0]          by_reg;
    logic [31:0]          ts_reg;
    logic                 blk_reg;

    logic                 hit_reg;
    logic                 tgt_reg;
    logic                 free_reg;
    logic                 claimed_reg;
    logic [31:0]          src_pk_reg;
    logic [31:0]          src_by_reg;
    logic [31:0]          tot_pk_reg;
    logic [31:0]          tot_by_reg;

    logic                 out_valid_reg;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic [6:0]           flow_count_reg;
    logic [6:0]           removed_out_reg;
    logic [31:0]          pk_out_reg;
    logic [31:0]          by_out_reg;

    entry_t               cell_in  [TABLE_DEPTH];
    entry_t               cell_out [TABLE_DEPTH];
    probe_t               probe_in [TABLE_DEPTH];
    probe_t               probe_out[TABLE_DEPTH];
    cell_ctrl_t           ctrl;

    entry_t               head;
    entry_t               head_mod;
    logic                 key_hit;
    logic                 tgt_hit;
    logic                 touch;
    logic                 create;

    logic [CNT_W:0]       cnt_ext;
    logic [CNT_W:0]       min_ext;
    logic [CNT_W-1:0]     budget;
    logic [CNT_W-1:0]     removed;

    // ------------------------------------------------------------------ ring of cells
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign cell_in[g]  = head_mod;
                assign probe_in[g] = probe_out[0];
            end
            else
            begin : g_mid
                assign cell_in[g]  = cell_out[g+1];
                assign probe_in[g] = probe_out[g+1];
            end

            ftwa_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .entry_in  (cell_in[g]),
                .entry_out (cell_out[g]),
                .probe_in  (probe_in[g]),
                .probe_out (probe_out[g])
            );
        end
    endgenerate

    assign head = cell_out[0];

    // Removal budget: how many candidates may go before the count reaches min_flows.
    always_comb
    begin
        cnt_ext = {1'b0, count_reg};
        min_ext = (CNT_W + 1)'(min_flows_reg);
        budget  = (cnt_ext > min_ext) ? CNT_W'(cnt_ext - min_ext) : '0;
        removed = (ncand_reg < budget) ? ncand_reg : budget;
    end

    always_comb
    begin
        ctrl.shift       = (state_reg == S_PASS1) || (state_reg == S_PASS2);
        ctrl.probe_load  = (state_reg == S_PLOAD);
        ctrl.probe_shift = (state_reg == S_PROBE);
        ctrl.prune       = (state_reg == S_PRUNE);
        ctrl.budget      = budget;
    end

    // ------------------------------------------------------------------ head rewrite
    always_comb
    begin
        key_hit  = head.valid && (head.key == key_reg);
        tgt_hit  = head.valid && (head.key == key2_reg);
        head_mod = head;
        touch    = 1'b0;
        create   = 1'b0;

        if (state_reg == S_PASS1 && cmd_reg == CMD_CLEAN)
        begin
            if (head.active)
            begin
                head_mod.idle   = '0;
                head_mod.active = 1'b0;
            end
            else if (head.idle != 8'hFF)
            begin
                head_mod.idle = head.idle + 8'd1;
            end
            head_mod.mark = head.valid && (head_mod.idle > max_idle_reg);
        end
        else if (state_reg == S_PASS2)
        begin
            case (cmd_reg)
                CMD_TRAFFIC, CMD_BLOCK:
                begin
                    create = !hit_reg && !head.valid && free_reg && !claimed_reg;
                    if (create)
                    begin
                        head_mod = '{valid: 1'b1, key: key_reg, default: '0};
                    end
                    if (create || (hit_reg && key_hit))
                    begin
                        touch = 1'b1;
                        if (cmd_reg == CMD_TRAFFIC)
                        begin
                            head_mod.packets   = head_mod.packets + 32'(pk_reg);
                            head_mod.bytes     = head_mod.bytes + 32'(by_reg);
                            head_mod.last_seen = ts_reg;
                            head_mod.active    = 1'b1;
                        end
                        else
                        begin
                            head_mod.blocked = blk_reg;
                        end
                    end
                end
                CMD_MERGE:
                begin
                    if (hit_reg && key_reg == key2_reg)
                    begin
                        touch = key_hit;
                    end
                    else if (hit_reg && tgt_reg)
                    begin
                        // Fold the source into the existing target entry.
                        if (tgt_hit)
                        begin
                            touch            = 1'b1;
                            head_mod.packets = head.packets + src_pk_reg;
                            head_mod.bytes   = head.bytes + src_by_reg;
                            head_mod.idle    = '0;
                            head_mod.active  = 1'b1;
                        end
                        else if (key_hit)
                        begin
                            head_mod.valid = 1'b0;
                        end
                    end
                    else if (hit_reg && key_hit)
                    begin
                        touch        = 1'b1;
                        head_mod.key = key2_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------ result
    always_comb
    begin
        status_next = ST_OK;
        count_next  = count_reg;
        case (cmd_reg)
            CMD_TRAFFIC, CMD_BLOCK:
            begin
                if (!hit_reg && free_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
                else if (!hit_reg)
                begin
                    status_next = ST_FULL;
                end
            end
            CMD_CLEAN:
            begin
                count_next = count_reg - removed_reg;
            end
            default:
            begin
                if (!hit_reg)
                begin
                    status_next = ST_NO_SRC;
                end
                else if (key_reg != key2_reg && tgt_reg)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------ control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            max_idle_reg  <= 8'd10;
            min_flows_reg <= 7'd5;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MAX_IDLE:  max_idle_reg  <= cfg_data;
                    REG_MIN_FLOWS: min_flows_reg <= cfg_data[6:0];
                    default:
                    begin
                    end
                endcase
            end

            // The finish step reloads the result register itself.
            if (out_valid_reg && out_ready && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg     <= cmd_t'(cmd);
                        key_reg     <= KEY_BITS'(peer_id);
                        key2_reg    <= KEY_BITS'(new_peer_id);
                        pk_reg      <= packet_count;
                        by_reg      <= byte_count;
                        ts_reg      <= time_stamp;
                        blk_reg     <= block_flag;
                        hit_reg     <= 1'b0;
                        tgt_reg     <= 1'b0;
                        free_reg    <= 1'b0;
                        claimed_reg <= 1'b0;
                        tot_pk_reg  <= '0;
                        tot_by_reg  <= '0;
                        ncand_reg   <= '0;
                        removed_reg <= '0;
                        cnt_reg     <= '0;
                        state_reg   <= S_PASS1;
                    end
                end
                S_PASS1:
                begin
                    if (key_hit)
                    begin
                        hit_reg    <= 1'b1;
                        src_pk_reg <= head.packets;
                        src_by_reg <= head.bytes;
                    end
                    if (tgt_hit)
                    begin
                        tgt_reg <= 1'b1;
                    end
                    if (!head.valid)
                    begin
                        free_reg <= 1'b1;
                    end
                    if (cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (cmd_reg == CMD_CLEAN) ? S_PLOAD : S_PASS2;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_PASS2:
                begin
                    if (touch)
                    begin
                        tot_pk_reg <= head_mod.packets;
                        tot_by_reg <= head_mod.bytes;
                    end
                    if (create)
                    begin
                        claimed_reg <= 1'b1;
                    end
                    if (cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_PLOAD:
                begin
                    state_reg <= S_PROBE;
                end
                S_PROBE:
                begin
                    if (probe_out[0].mark)
                    begin
                        ncand_reg <= ncand_reg + 1'b1;
                    end
                    if (cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_PRUNE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_PRUNE:
                begin
                    removed_reg <= removed;
                    state_reg   <= S_FINISH;
                end
                S_FINISH:
                begin
                    // The result waits here while the previous one is still held.
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= status_next;
                        count_reg       <= count_next;
                        flow_count_reg  <= 7'(count_next);
                        removed_out_reg <= 7'(removed_reg);
                        pk_out_reg      <= tot_pk_reg;
                        by_out_reg      <= tot_by_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign flow_count    = flow_count_reg;
    assign removed_count = removed_out_reg;
    assign packet_total  = pk_out_reg;
    assign byte_total    = by_out_reg;

endmodule

### design/ftwa_checker.sv
module ftwa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [6:0]  flow_count,
    input logic [6:0]  removed_count,
    input logic [31:0] packet_total,
    input logic [31:0] byte_total
);
    import ftwa_pkg::*;

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(flow_count)
            && $stable(packet_total) && $stable(byte_total))
        else $error("result changed while stalled");

    // Status is one of the three defined codes.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    // The table never holds more entries than it has slots.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> flow_count <= 7'(TABLE_DEPTH))
        else $error("flow count beyond table depth");

    // A failed command reports no totals.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> packet_total == 32'd0 && byte_total == 32'd0
            && removed_count == 7'd0)
        else $error("failed command reported totals");

    // A clean tick that removed entries reports no totals.
    a_clean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && removed_count != 7'd0 |-> packet_total == 32'd0 && byte_total == 32'd0)
        else $error("clean tick reported totals");

endmodule

bind flow_table_with_aging ftwa_checker u_ftwa_checker (.*);

### dv/testbench.sv
module testbench;
    import ftwa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One result per item; the scoreboard keeps its own copy of the flow table
    // and predicts the result of every accepted item in order.
    typedef struct {
        logic [1:0]  status;
        logic [6:0]  flow_count;
        logic [6:0]  removed_count;
        logic [31:0] packet_total;
        logic [31:0] byte_total;
    } flow_result_t;

    class flow_scoreboard;
        bit          live[TABLE_DEPTH];
        bit [15:0]   key[TABLE_DEPTH];
        bit          blocked[TABLE_DEPTH];
        bit [31:0]   packets[TABLE_DEPTH];
        bit [31:0]   bytes[TABLE_DEPTH];
        bit [31:0]   seen[TABLE_DEPTH];
        bit [7:0]    idle[TABLE_DEPTH];
        bit          active[TABLE_DEPTH];
        int          count;
        int          max_idle;
        int          min_flows;
        flow_result_t pending[$];
        int          errors;

        function new();
            max_idle = 10;
            min_flows = 5;
            count = 0;
            errors = 0;
            foreach (live[i]) live[i] = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [7:0] data);
            if (idx == REG_MAX_IDLE) max_idle = data;
            else if (idx == REG_MIN_FLOWS) min_flows = data[6:0];
        endfunction

        function int lookup(bit [15:0] k);
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (live[i] && key[i] == k) return i;
            return -1;
        endfunction

        function int lookup_or_insert(bit [15:0] k);
            int i;
            i = lookup(k);
            if (i >= 0) return i;
            for (i = 0; i < TABLE_DEPTH; i++)
                if (!live[i])
                begin
                    live[i] = 1; key[i] = k; blocked[i] = 0; packets[i] = 0;
                    bytes[i] = 0; seen[i] = 0; idle[i] = 0; active[i] = 0;
                    count++;
                    return i;
                end
            return -1;
        endfunction

        // Ages every entry in ascending key order and prunes idle ones.
        function int age_table();
            int removed;
            int best;
            int prev;
            removed = 0;
            prev = -1;
            forever
            begin
                best = -1;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (live[i] && int'(key[i]) > prev && (best < 0 || key[i] < key[best]))
                        best = i;
                if (best < 0) break;
                prev = key[best];
                if (active[best])
                begin
                    idle[best] = 0;
                    active[best] = 0;
                end
                else if (idle[best] != 8'd255) idle[best]++;
                if (count > min_flows && int'(idle[best]) > max_idle)
                begin
                    live[best] = 0;
                    count--;
                    removed++;
                end
            end
            return removed;
        endfunction

        function void note_item(cmd_t c, bit [15:0] pid, bit [15:0] nid, bit [15:0] pk,
                                bit [23:0] by, bit [31:0] ts, bit blk);
            flow_result_t r;
            int i;
            int j;
            r = '{ST_OK, 0, 0, 0, 0};
            if (c == CMD_TRAFFIC || c == CMD_BLOCK)
            begin
                i = lookup_or_insert(pid);
                if (i < 0) r.status = ST_FULL;
                else
                begin
                    if (c == CMD_TRAFFIC)
                    begin
                        packets[i] += pk;
                        bytes[i] += by;
                        seen[i] = ts;
                        active[i] = 1;
                    end
                    else blocked[i] = blk;
                    r.packet_total = packets[i];
                    r.byte_total = bytes[i];
                end
            end
            else if (c == CMD_CLEAN) r.removed_count = age_table();
            else
            begin
                i = lookup(pid);
                if (i < 0) r.status = ST_NO_SRC;
                else if (pid == nid)
                begin
                    r.packet_total = packets[i];
                    r.byte_total = bytes[i];
                end
                else
                begin
                    j = lookup(nid);
                    if (j >= 0)
                    begin
                        packets[j] += packets[i];
                        bytes[j] += bytes[i];
                        idle[j] = 0;
                        active[j] = 1;
                        live[i] = 0;
                        count--;
                        r.packet_total = packets[j];
                        r.byte_total = bytes[j];
                    end
                    else
                    begin
                        key[i] = nid;
                        r.packet_total = packets[i];
                        r.byte_total = bytes[i];
                    end
                end
            end
            r.flow_count = count[6:0];
            pending.push_back(r);
        endfunction

        function void check_result(flow_result_t act);
            flow_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %0d flows %0d", $realtime,
                         act.status, act.flow_count);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.status !== act.status)
            begin
                $display("%0t: status expected %0d actual %0d", $realtime, e.status, act.status);
                errors++;
            end
            if (e.flow_count !== act.flow_count)
            begin
                $display("%0t: flow_count expected %0d actual %0d", $realtime, e.flow_count,
                         act.flow_count);
                errors++;
            end
            if (e.removed_count !== act.removed_count)
            begin
                $display("%0t: removed_count expected %0d actual %0d", $realtime,
                         e.removed_count, act.removed_count);
                errors++;
            end
            if (e.packet_total !== act.packet_total)
            begin
                $display("%0t: packet_total expected %h actual %h", $realtime, e.packet_total,
                         act.packet_total);
                errors++;
            end
            if (e.byte_total !== act.byte_total)
            begin
                $display("%0t: byte_total expected %h actual %h", $realtime, e.byte_total,
                         act.byte_total);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [15:0] peer_id;
    logic [15:0] new_peer_id;
    logic [15:0] packet_count;
    logic [23:0] byte_count;
    logic [31:0] time_stamp;
    logic        block_flag;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [6:0]  flow_count;
    logic [6:0]  removed_count;
    logic [31:0] packet_total;
    logic [31:0] byte_total;

    flow_table_with_aging dut (.*);

    flow_scoreboard flows = new();
    int cycle_count;
    int stall_mode;
    // Peer ids mostly come from a small pool so that lookups hit and merges find targets.
    bit [15:0] peer_pool[16];

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // The cycle limit is far above the slowest run: about 1900 items, each taking a full command,
    // plus sender gaps and receiver stalls.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: sample at the rising edge, change ready at the falling edge.
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            flows.check_result('{status, flow_count, removed_count, packet_total, byte_total});

    always @(negedge clk)
    begin
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= cycle_count[3];
        endcase
    end

    // The block takes no new item until the result of the accepted one is registered, so the
    // extra falling edge at the end costs nothing and keeps the drive of valid clean.
    task automatic send_item(cmd_t c, bit [15:0] pid, bit [15:0] nid, bit [15:0] pk,
                             bit [23:0] by, bit [31:0] ts, bit blk);
        cmd <= c;
        peer_id <= pid;
        new_peer_id <= nid;
        packet_count <= pk;
        byte_count <= by;
        time_stamp <= ts;
        block_flag <= blk;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        flows.note_item(c, pid, nid, pk, by, ts, blk);
        @(negedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_gap();
        int gap;
        if ($urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 20);
            repeat (gap) @(negedge clk);
        end
    endtask

    // Configuration is only written when every result is in and the block has had
    // time to settle.
    task automatic write_reg(logic [7:0] idx, logic [7:0] data);
        while (flows.pending.size() != 0) @(negedge clk);
        repeat (140) @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        flows.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic bit [15:0] pick_peer();
        if ($urandom_range(0, 9) < 8) return peer_pool[$urandom_range(0, 15)];
        return 16'($urandom);
    endfunction

    task automatic random_item(int clean_weight);
        int sel;
        bit [15:0] pid;
        sel = $urandom_range(0, 99);
        pid = pick_peer();
        if (sel < clean_weight)
            send_item(CMD_CLEAN, 16'($urandom), 16'($urandom), 16'($urandom),
                      24'($urandom), $urandom, 1'($urandom));
        else if (sel < 60)
            send_item(CMD_TRAFFIC, pid, 16'($urandom), 16'($urandom),
                      24'($urandom), $urandom, 1'($urandom));
        else if (sel < 75)
            send_item(CMD_BLOCK, pid, 16'($urandom), 16'($urandom),
                      24'($urandom), $urandom, 1'($urandom));
        else
            send_item(CMD_MERGE, pid, ($urandom_range(0, 5) == 0) ? pid : pick_peer(),
                      16'($urandom), 24'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic random_phase(int items, int clean_weight);
        int burst;
        int sent;
        sent = 0;
        while (sent < items)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                random_item(clean_weight);
                sent++;
            end
            random_gap();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = CMD_TRAFFIC;
        peer_id = '0;
        new_peer_id = '0;
        packet_count = '0;
        byte_count = '0;
        time_stamp = '0;
        block_flag = 1'b0;
        out_ready = 1'b1;
        stall_mode = 0;
        cycle_count = 0;
        foreach (peer_pool[i]) peer_pool[i] = 16'($urandom);
        peer_pool[0] = 16'h0000;
        peer_pool[1] = 16'hFFFF;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: extreme fields, every command, merge corner cases.
        send_item(CMD_MERGE, 16'h1234, 16'h4321, 0, 0, 0, 0);
        send_item(CMD_TRAFFIC, 16'h0000, 0, 16'hFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 0);
        send_item(CMD_TRAFFIC, 16'h0000, 0, 16'hFFFF, 24'hFFFFFF, 32'h0, 1);
        send_item(CMD_TRAFFIC, 16'hFFFF, 16'hFFFF, 0, 0, 32'h5A5A5A5A, 0);
        send_item(CMD_BLOCK, 16'hFFFF, 0, 0, 0, 0, 1);
        send_item(CMD_BLOCK, 16'h00AA, 0, 0, 0, 0, 0);
        send_item(CMD_MERGE, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0);
        send_item(CMD_MERGE, 16'h00AA, 16'h0000, 0, 0, 0, 0);
        send_item(CMD_MERGE, 16'h0000, 16'h7777, 0, 0, 0, 0);
        send_item(CMD_CLEAN, 0, 0, 0, 0, 0, 0);
        send_item(CMD_CLEAN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 1);

        // Fill the table past its depth so inserts are dropped.
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
            send_item(CMD_TRAFFIC, 16'(16'h8000 + i), 0, 1, 1, i, 0);

        // Tiny thresholds drain the full table with successive clean ticks.
        write_reg(REG_MAX_IDLE, 8'd0);
        write_reg(REG_MIN_FLOWS, 8'd0);
        repeat (3) send_item(CMD_CLEAN, 0, 0, 0, 0, 0, 0);

        stall_mode = 1;
        random_phase(500, 10);

        write_reg(REG_MAX_IDLE, 8'd254);
        write_reg(REG_MIN_FLOWS, 8'd64);
        stall_mode = 2;
        random_phase(300, 15);

        // Idle counts saturate only after many ticks with no traffic.
        write_reg(REG_MIN_FLOWS, 8'd3);
        stall_mode = 0;
        repeat (260) send_item(CMD_CLEAN, 0, 0, 0, 0, 0, 0);

        write_reg(REG_MAX_IDLE, 8'd2);
        write_reg(REG_MIN_FLOWS, 8'd8);
        stall_mode = 3;
        random_phase(400, 20);

        write_reg(REG_MAX_IDLE, 8'd10);
        write_reg(REG_MIN_FLOWS, 8'd5);
        stall_mode = 1;
        random_phase(400, 12);

        while (flows.pending.size() != 0) @(negedge clk);
        repeat (140) @(negedge clk);
        if (flows.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### sim.f
design/ftwa_pkg.sv
design/ftwa_cell.sv
design/flow_table_with_aging.sv
design/ftwa_checker.sv
dv/testbench.sv
